// ----- rtl/ui2x_pkg.sv -----
// Shared constants and types for the 2x image upscaler.
// No dependencies; used by every module of the block but ui2x_ram.
package ui2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IDX_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

    // row / column slot within the block of results of one source pixel
    localparam logic [1:0] SLOT_PRE  = 2'd0;   // 2x-1
    localparam logic [1:0] SLOT_MID  = 2'd1;   // 2x
    localparam logic [1:0] SLOT_POST = 2'd2;   // 2x+1

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             has_left;
        logic             last_c;
        logic             last_r;
        logic [PIX_W-1:0] v_diag;
        logic [PIX_W-1:0] v_vert;
        logic [PIX_W-1:0] v_horz;
        logic [PIX_W-1:0] v_pix;
    } t_job;

endpackage

// ----- rtl/ui2x_ram.sv -----
// Generic single-port RAM, registered read, read-before-write.
// No dependencies.
module ui2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ui2x_front.sv -----
// Input side: raster counters, line store read/write, neighbour averages.
// Depends on ui2x_pkg and ui2x_ram.
module ui2x_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ui2x_pkg::PIX_W-1:0] i_pixel,
    input  logic [ui2x_pkg::COL_W-1:0] i_w_last,
    input  logic [ui2x_pkg::ROW_W-1:0] i_h_last,
    input  logic                       i_restart,
    output logic                       o_job_valid,
    output ui2x_pkg::t_job             o_job,
    input  logic                       i_job_ready
);

    logic                       r_s1_valid, n_s1_valid;
    logic [ui2x_pkg::PIX_W-1:0] r_s1_pix, r_s1_left;
    logic [ui2x_pkg::ROW_W-1:0] r_s1_row;
    logic [ui2x_pkg::COL_W-1:0] r_s1_col;
    logic                       r_s1_lastc, r_s1_lastr;

    logic [ui2x_pkg::COL_W-1:0] r_col, n_col;
    logic [ui2x_pkg::ROW_W-1:0] r_row, n_row;
    logic [ui2x_pkg::PIX_W-1:0] r_left, n_left;
    logic [ui2x_pkg::PIX_W-1:0] r_prev_up;

    logic                       accept, advance, last_c, last_r;
    logic [ui2x_pkg::PIX_W-1:0] up;
    logic [ui2x_pkg::PIX_W:0]   sum_h, sum_v, sum_u, sum_d;
    logic [ui2x_pkg::PIX_W-1:0] hmid, vmid, umid;

    assign advance    = r_s1_valid && i_job_ready;
    assign o_in_ready = !r_s1_valid || i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign last_c     = (r_col == i_w_last);
    assign last_r     = (r_row == i_h_last);

    // read-before-write: the old entry is the row above, the new pixel replaces it.
    // Read data holds until the next request is taken.
    ui2x_ram #(
        .WIDTH (ui2x_pkg::PIX_W),
        .DEPTH (ui2x_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (accept),
        .i_addr  (r_col),
        .i_wdata (i_pixel),
        .o_rdata (up)
    );

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_left = '0;
        end else if (accept) begin
            if (last_c) begin
                n_col  = '0;
                n_left = '0;
                n_row  = last_r ? '0 : r_row + ui2x_pkg::ROW_W'(1);
            end else begin
                n_col  = r_col + ui2x_pkg::COL_W'(1);
                n_left = i_pixel;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_left     <= n_left;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_pixel;
            r_s1_left  <= r_left;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s1_lastc <= last_c;
            r_s1_lastr <= last_r;
        end
        // the row-above pixel of this column is the up-left of the next one
        if (advance) begin
            r_prev_up <= up;
        end
    end

    assign sum_h = {1'b0, r_s1_left} + {1'b0, r_s1_pix};
    assign sum_v = {1'b0, up} + {1'b0, r_s1_pix};
    assign sum_u = {1'b0, r_prev_up} + {1'b0, up};
    assign hmid  = sum_h[ui2x_pkg::PIX_W:1];
    assign vmid  = sum_v[ui2x_pkg::PIX_W:1];
    assign umid  = sum_u[ui2x_pkg::PIX_W:1];
    assign sum_d = {1'b0, umid} + {1'b0, hmid};

    always_comb begin
        o_job          = '0;
        o_job.row      = r_s1_row;
        o_job.col      = r_s1_col;
        o_job.has_up   = (r_s1_row != '0);
        o_job.has_left = (r_s1_col != '0);
        o_job.last_c   = r_s1_lastc;
        o_job.last_r   = r_s1_lastr;
        o_job.v_diag   = sum_d[ui2x_pkg::PIX_W:1];
        o_job.v_vert   = vmid;
        o_job.v_horz   = hmid;
        o_job.v_pix    = r_s1_pix;
    end

    assign o_job_valid = r_s1_valid;

endmodule

// ----- rtl/ui2x_emit.sv -----
// Output sequencer: walks the up to nine results of one source pixel.
// Depends on ui2x_pkg.
module ui2x_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  ui2x_pkg::t_job               i_job,
    output logic                         o_job_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ui2x_pkg::COORD_W-1:0] o_out_row,
    output logic [ui2x_pkg::COORD_W-1:0] o_out_col,
    output logic [ui2x_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                         o_run_last,
    output logic                         o_frame_last
);

    ui2x_pkg::t_job r_job;
    logic           r_busy, n_busy;
    logic [1:0]     r_rs, n_rs, r_cs, n_cs;
    logic           r_ov, n_ov;
    logic [ui2x_pkg::COORD_W-1:0] r_orow, r_ocol;
    logic [ui2x_pkg::PIX_W-1:0]   r_opix;
    logic           r_orl, r_ofl;

    logic       load_out, is_last, take_job;
    logic [1:0] rs_end, cs_start, cs_end;
    logic [1:0] job_rs, job_cs;
    logic [ui2x_pkg::COORD_W-1:0] cur_row, cur_col;
    logic [ui2x_pkg::PIX_W-1:0]   cur_pix;

    assign rs_end   = r_job.last_r ? ui2x_pkg::SLOT_POST : ui2x_pkg::SLOT_MID;
    assign cs_end   = r_job.last_c ? ui2x_pkg::SLOT_POST : ui2x_pkg::SLOT_MID;
    assign cs_start = r_job.has_left ? ui2x_pkg::SLOT_PRE : ui2x_pkg::SLOT_MID;
    assign job_rs   = i_job.has_up ? ui2x_pkg::SLOT_PRE : ui2x_pkg::SLOT_MID;
    assign job_cs   = i_job.has_left ? ui2x_pkg::SLOT_PRE : ui2x_pkg::SLOT_MID;

    assign load_out    = r_busy && (!r_ov || i_out_ready);
    assign is_last     = (r_rs == rs_end) && (r_cs == cs_end);
    assign o_job_ready = !r_busy || (load_out && is_last);
    assign take_job    = i_job_valid && o_job_ready;

    // slot code is the offset from 2x-1
    assign cur_row = ui2x_pkg::COORD_W'({r_job.row, 1'b0}) + ui2x_pkg::COORD_W'(r_rs)
                   - ui2x_pkg::COORD_W'(1);
    assign cur_col = ui2x_pkg::COORD_W'({r_job.col, 1'b0}) + ui2x_pkg::COORD_W'(r_cs)
                   - ui2x_pkg::COORD_W'(1);

    always_comb begin
        if (r_rs == ui2x_pkg::SLOT_PRE) begin
            cur_pix = (r_cs == ui2x_pkg::SLOT_PRE) ? r_job.v_diag : r_job.v_vert;
        end else begin
            cur_pix = (r_cs == ui2x_pkg::SLOT_PRE) ? r_job.v_horz : r_job.v_pix;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_rs   = r_rs;
        n_cs   = r_cs;
        priority if (take_job) begin
            n_busy = 1'b1;
            n_rs   = job_rs;
            n_cs   = job_cs;
        end else if (load_out && is_last) begin
            n_busy = 1'b0;
        end else if (load_out) begin
            if (r_cs == cs_end) begin
                n_rs = r_rs + 2'd1;
                n_cs = cs_start;
            end else begin
                n_cs = r_cs + 2'd1;
            end
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (load_out) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_rs   <= ui2x_pkg::SLOT_MID;
            r_cs   <= ui2x_pkg::SLOT_MID;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
            r_rs   <= n_rs;
            r_cs   <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_orow <= cur_row;
            r_ocol <= cur_col;
            r_opix <= cur_pix;
            r_orl  <= is_last;
            r_ofl  <= is_last && r_job.last_c && r_job.last_r;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_out_pixel  = r_opix;
    assign o_run_last   = r_orl;
    assign o_frame_last = r_ofl;

endmodule

// ----- rtl/image_upscale_2x_interpolate_unit.sv -----
// 2x upscaler top: configuration registers, front end and output sequencer.
// Requests are registered in the front stage and the job register, results in the output
// register. Throughput: one result per cycle unless the output stalls, set by the single
// output register; a request yields 1 to 9 results (about 4 on average).
// Reset: synchronous active low; size 1x1, frame restarts. Line store is not cleared.
module image_upscale_2x_interpolate_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ui2x_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [ui2x_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ui2x_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ui2x_pkg::COORD_W-1:0] o_out_row,
    output logic [ui2x_pkg::COORD_W-1:0] o_out_col,
    output logic [ui2x_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                         o_run_last,
    output logic                         o_frame_last
);

    logic [ui2x_pkg::COL_W-1:0] r_w_last, n_w_last;
    logic [ui2x_pkg::ROW_W-1:0] r_h_last, n_h_last;
    logic                       cfg_wr, restart;
    logic                       job_valid, job_ready;
    ui2x_pkg::t_job             job;
    logic [ui2x_pkg::CFG_W-1:0] dm1;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign dm1         = i_cfg_data - ui2x_pkg::CFG_W'(1);

    // stored as size minus one, zero treated as one, saturated at the maximum
    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        restart  = 1'b0;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                ui2x_pkg::REG_WIDTH: begin
                    restart = 1'b1;
                    if (i_cfg_data == '0) begin
                        n_w_last = '0;
                    end else if (i_cfg_data > ui2x_pkg::CFG_W'(ui2x_pkg::MAX_WIDTH)) begin
                        n_w_last = ui2x_pkg::COL_W'(ui2x_pkg::MAX_WIDTH - 1);
                    end else begin
                        n_w_last = dm1[ui2x_pkg::COL_W-1:0];
                    end
                end
                ui2x_pkg::REG_HEIGHT: begin
                    restart = 1'b1;
                    if (i_cfg_data == '0) begin
                        n_h_last = '0;
                    end else if (i_cfg_data > ui2x_pkg::CFG_W'(ui2x_pkg::MAX_HEIGHT)) begin
                        n_h_last = ui2x_pkg::ROW_W'(ui2x_pkg::MAX_HEIGHT - 1);
                    end else begin
                        n_h_last = dm1[ui2x_pkg::ROW_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= '0;
            r_h_last <= '0;
        end else begin
            r_w_last <= n_w_last;
            r_h_last <= n_h_last;
        end
    end

    ui2x_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .i_w_last    (r_w_last),
        .i_h_last    (r_h_last),
        .i_restart   (restart),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    ui2x_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_ready  (job_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_pixel  (o_out_pixel),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

endmodule
